// File: src/scara_inverse_kinematics_assert.svh
// Assertion macros used by the arm solver top module.
`ifndef SCARA_INVERSE_KINEMATICS_ASSERT_SVH
`define SCARA_INVERSE_KINEMATICS_ASSERT_SVH
`ifndef ASSERT_OFF
`define SIK_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sik assertion failed");
`define SIK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sik assertion failed");
`else
`define SIK_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SIK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/sik_pkg.sv
package sik_pkg;

   localparam int CORDIC_STAGES = 24;
   localparam int CORDIC_DEPTH = CORDIC_STAGES + 1;

   localparam int LEN_W = 20;
   localparam int COORD_W = 24;
   localparam int SQ_W = 48;
   localparam int PROD_W = 40;
   localparam int NUM_W = 50;
   localparam int DEN_W = 46;
   localparam int REM_W = DEN_W + 1;
   localparam int RATIO_W = 32;
   localparam int DIV_STEPS = 30;
   localparam int DIV_DEPTH = DIV_STEPS + 1;
   localparam int ROOT_IN_W = 62;
   localparam int ROOT_W = 31;
   localparam int ROOT_STEPS = 31;
   localparam int ANGLE_W = 32;
   localparam int ELBOW_W = 30;
   localparam int CV_W = 34;
   localparam int NORM_W = 32;
   localparam int NORM_STEPS = 5;
   localparam int NORM_MAX_SHIFT = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic signed [ANGLE_W-1:0] Q_PI = 32'sd843314857;
   localparam logic signed [ANGLE_W-1:0] Q_TWO_PI = 32'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] Q_HALF_PI = 32'sd421657428;
   localparam logic signed [RATIO_W-1:0] ONE_Q30 = 32'sd1073741824;
   localparam logic [ROOT_IN_W-1:0] ONE_Q60 = ROOT_IN_W'(1) << 60;
   localparam logic [ELBOW_W-1:0] ELBOW_MAX = 30'd843314857;
   localparam logic [LEN_W-1:0] LINK_RESET = 20'd25600;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_A = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_B = 2'd1;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CLAMPED = 2'd1,
      STATUS_ORIGIN  = 2'd2
   } status_type;

   typedef struct packed {
      logic                      y_neg;
      logic                      rr_zero;
      logic                      clamp1;
      logic                      clamp2;
      logic [LEN_W-1:0]          link_a;
      logic signed [NUM_W-1:0]   num2;
      logic signed [NORM_W-1:0]  norm_x;
      logic signed [NORM_W-1:0]  norm_y;
      logic signed [RATIO_W-1:0] c1;
      logic [ROOT_W-1:0]         s1;
      logic signed [RATIO_W-1:0] c2;
   } ctx_type;

   function automatic logic signed [ANGLE_W-1:0] atan_step(input int unsigned i);
      logic signed [ANGLE_W-1:0] v;
      case (i)
         0:       v = 32'sd210828714;
         1:       v = 32'sd124459457;
         2:       v = 32'sd65760959;
         3:       v = 32'sd33381290;
         4:       v = 32'sd16755422;
         5:       v = 32'sd8385879;
         6:       v = 32'sd4193963;
         7:       v = 32'sd2097109;
         8:       v = 32'sd1048571;
         9:       v = 32'sd524287;
         10:      v = 32'sd262144;
         default: v = (i <= 28) ? (ANGLE_W'(1) << (28 - i)) : '0;
      endcase
      return v;
   endfunction

endpackage

// File: src/sik_isqrt.sv
module sik_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  sik_pkg::ctx_type                 in_ctx,
   input  logic [sik_pkg::ROOT_IN_W-1:0]    in_value,
   output logic                             out_valid,
   output sik_pkg::ctx_type                 out_ctx,
   output logic [sik_pkg::ROOT_W-1:0]       out_root
);
   import sik_pkg::*;

   logic [ROOT_STEPS-1:0] valid_ff;
   ctx_type               ctx_ff [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  rem_ff [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  res_ff [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  rem_in [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  res_in [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  rem_prev [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  res_prev [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  bit_val [ROOT_STEPS];
   logic [ROOT_IN_W-1:0]  trial [ROOT_STEPS];

   always_comb begin
      rem_prev[0] = in_value;
      res_prev[0] = '0;
      for (int k = 1; k < ROOT_STEPS; k++) begin
         rem_prev[k] = rem_ff[k-1];
         res_prev[k] = res_ff[k-1];
      end
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bit_val[k] = ROOT_IN_W'(1) << (2 * (ROOT_STEPS - 1 - k));
         trial[k] = res_prev[k] + bit_val[k];
         if (rem_prev[k] >= trial[k]) begin
            rem_in[k] = rem_prev[k] - trial[k];
            res_in[k] = (res_prev[k] >> 1) + bit_val[k];
         end else begin
            rem_in[k] = rem_prev[k];
            res_in[k] = res_prev[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[ROOT_STEPS-2:0], in_valid};
      end
      if (advance) begin
         ctx_ff[0] <= in_ctx;
         for (int k = 1; k < ROOT_STEPS; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
         for (int k = 0; k < ROOT_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS-1];
   assign out_ctx = ctx_ff[ROOT_STEPS-1];
   assign out_root = res_ff[ROOT_STEPS-1][ROOT_W-1:0];

endmodule

// File: src/sik_divider.sv
module sik_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  sik_pkg::ctx_type                    in_ctx,
   input  logic signed [sik_pkg::NUM_W-1:0]    in_num,
   input  logic [sik_pkg::DEN_W-1:0]           in_den,
   output logic                                out_valid,
   output sik_pkg::ctx_type                    out_ctx,
   output logic signed [sik_pkg::RATIO_W-1:0]  out_ratio,
   output logic                                out_clamp
);
   import sik_pkg::*;

   logic [DIV_DEPTH-1:0]  valid_ff;
   ctx_type               ctx_ff [DIV_DEPTH];
   logic [REM_W-1:0]      rem_ff [DIV_DEPTH];
   logic [DIV_STEPS-1:0]  quo_ff [DIV_DEPTH];
   logic [DEN_W-1:0]      den_ff [DIV_DEPTH];
   logic [DIV_DEPTH-1:0]  neg_ff;
   logic [DIV_DEPTH-1:0]  special_ff;
   logic [DIV_DEPTH-1:0]  clamp_ff;
   logic [REM_W-1:0]      rem_in [DIV_DEPTH];
   logic [DIV_STEPS-1:0]  quo_in [DIV_DEPTH];
   logic [REM_W-1:0]      shifted [DIV_DEPTH];
   logic [NUM_W-1:0]      mag;
   logic [NUM_W-1:0]      den_ext;
   logic                  den_zero;
   logic                  over;
   logic                  equal;
   logic signed [RATIO_W-1:0] quo_signed;

   always_comb begin
      mag = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);
      den_ext = NUM_W'(in_den);
      den_zero = (in_den == '0);
      over = (mag > den_ext);
      equal = (mag == den_ext);
      rem_in[0] = REM_W'(mag);
      quo_in[0] = '0;
      shifted[0] = '0;
      for (int k = 1; k < DIV_DEPTH; k++) begin
         shifted[k] = {rem_ff[k-1][REM_W-2:0], 1'b0};
         if (shifted[k] >= REM_W'(den_ff[k-1])) begin
            rem_in[k] = shifted[k] - REM_W'(den_ff[k-1]);
            quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in[k] = shifted[k];
            quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[DIV_DEPTH-2:0], in_valid};
      end
      if (advance) begin
         ctx_ff[0] <= in_ctx;
         den_ff[0] <= in_den;
         neg_ff[0] <= in_num[NUM_W-1];
         special_ff[0] <= den_zero | over | equal;
         clamp_ff[0] <= den_zero | over;
         for (int k = 1; k < DIV_DEPTH; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            special_ff[k] <= special_ff[k-1];
            clamp_ff[k] <= clamp_ff[k-1];
         end
         for (int k = 0; k < DIV_DEPTH; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo_signed = signed'(RATIO_W'(quo_ff[DIV_DEPTH-1]));

   always_comb begin
      if (special_ff[DIV_DEPTH-1]) begin
         out_ratio = neg_ff[DIV_DEPTH-1] ? -ONE_Q30 : ONE_Q30;
      end else begin
         out_ratio = neg_ff[DIV_DEPTH-1] ? -quo_signed : quo_signed;
      end
   end

   assign out_valid = valid_ff[DIV_DEPTH-1];
   assign out_ctx = ctx_ff[DIV_DEPTH-1];
   assign out_clamp = clamp_ff[DIV_DEPTH-1];

endmodule

// File: src/sik_cordic.sv
module sik_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  sik_pkg::ctx_type                    in_ctx,
   input  logic signed [sik_pkg::RATIO_W-1:0]  in_cos,
   input  logic [sik_pkg::ROOT_W-1:0]          in_sin,
   output logic                                out_valid,
   output sik_pkg::ctx_type                    out_ctx,
   output logic signed [sik_pkg::ANGLE_W-1:0]  out_angle
);
   import sik_pkg::*;

   logic [CORDIC_DEPTH-1:0]    valid_ff;
   ctx_type                    ctx_ff [CORDIC_DEPTH];
   logic signed [CV_W-1:0]     x_ff [CORDIC_STAGES];
   logic signed [CV_W-1:0]     y_ff [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0]  z_ff [CORDIC_STAGES];
   logic signed [CV_W-1:0]     x_prev [CORDIC_STAGES];
   logic signed [CV_W-1:0]     y_prev [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0]  z_prev [CORDIC_STAGES];
   logic signed [CV_W-1:0]     x_in [CORDIC_STAGES];
   logic signed [CV_W-1:0]     y_in [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0]  z_in [CORDIC_STAGES];
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic signed [ANGLE_W-1:0]  angle_in;
   logic signed [ANGLE_W-1:0]  z_last;

   always_comb begin
      x_prev[0] = signed'(CV_W'(in_sin));
      y_prev[0] = -(CV_W'(in_cos));
      z_prev[0] = Q_HALF_PI;
      for (int k = 1; k < CORDIC_STAGES; k++) begin
         x_prev[k] = x_ff[k-1];
         y_prev[k] = y_ff[k-1];
         z_prev[k] = z_ff[k-1];
      end
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (!y_prev[k][CV_W-1]) begin
            x_in[k] = x_prev[k] + (y_prev[k] >>> k);
            y_in[k] = y_prev[k] - (x_prev[k] >>> k);
            z_in[k] = z_prev[k] + atan_step(k);
         end else begin
            x_in[k] = x_prev[k] - (y_prev[k] >>> k);
            y_in[k] = y_prev[k] + (x_prev[k] >>> k);
            z_in[k] = z_prev[k] - atan_step(k);
         end
      end
      z_last = z_ff[CORDIC_STAGES-1];
      if (z_last < 0) begin
         angle_in = '0;
      end else if (z_last > Q_PI) begin
         angle_in = Q_PI;
      end else begin
         angle_in = z_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[CORDIC_DEPTH-2:0], in_valid};
      end
      if (advance) begin
         ctx_ff[0] <= in_ctx;
         for (int k = 1; k < CORDIC_DEPTH; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            z_ff[k] <= z_in[k];
         end
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff[CORDIC_DEPTH-1];
   assign out_ctx = ctx_ff[CORDIC_DEPTH-1];
   assign out_angle = angle_ff;

endmodule

// File: src/scara_inverse_kinematics.sv
// Three 31-step root/divide sections in series are followed by the angle CORDICs.
// Throughput: one beat per cycle; a stalled rsp beat holds every stage in place.
// Reset (synchronous, active high) empties the pipeline and loads both links with 25600.
`include "scara_inverse_kinematics_assert.svh"

module scara_inverse_kinematics (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [47:0]                         req_tdata,   // target_x, target_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,   // base_angle, elbow_angle, zero pad
   output logic [2:0]                          rsp_tuser,   // solve_status, alpha_warning
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sik_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sik_pkg::LEN_W-1:0]           csr_data
);
   import sik_pkg::*;

   logic advance;

   logic [LEN_W-1:0] link_a_ff;
   logic [LEN_W-1:0] link_b_ff;

   logic                      in_valid_ff;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;

   logic                      a_valid_ff;
   logic signed [SQ_W-1:0]    xx_in;
   logic signed [SQ_W-1:0]    yy_in;
   logic [SQ_W-1:0]           xx_ff;
   logic [SQ_W-1:0]           yy_ff;
   logic [PROD_W-1:0]         aa_ff;
   logic [PROD_W-1:0]         bb_ff;
   logic [PROD_W-1:0]         ab_ff;
   logic [LEN_W-1:0]          a_link_ff;
   logic                      a_yneg_ff;
   logic [COORD_W-1:0]        abs_x;
   logic [COORD_W-1:0]        abs_y;
   logic [NORM_W-1:0]         norm_m;
   logic signed [NORM_W-1:0]  nx_in;
   logic signed [NORM_W-1:0]  ny_in;
   logic signed [NORM_W-1:0]  nx_ff;
   logic signed [NORM_W-1:0]  ny_ff;

   logic                      b_valid_ff;
   logic [SQ_W-1:0]           rr_in;
   logic [SQ_W-1:0]           rr_ff;
   logic signed [NUM_W-1:0]   num1_in;
   logic signed [NUM_W-1:0]   num1_ff;
   logic [DEN_W-1:0]          den1_ff;
   ctx_type                   b_ctx_in;
   ctx_type                   b_ctx_ff;

   logic                      p1_valid;
   ctx_type                   p1_ctx;
   logic signed [RATIO_W-1:0] p1_ratio;
   logic                      p1_clamp;
   logic [ROOT_W-1:0]         p1_root;

   logic                      m_valid_ff;
   ctx_type                   m_ctx_in;
   ctx_type                   m_ctx_ff;
   logic [LEN_W+ROOT_W-1:0]   den2_prod;
   logic [DEN_W-1:0]          den2_ff;
   logic signed [2*RATIO_W-1:0] cc1_prod;
   logic [ROOT_IN_W-1:0]      cc1_ff;

   logic                      m2_valid_ff;
   ctx_type                   m2_ctx_ff;
   logic [DEN_W-1:0]          m2_den_ff;
   logic [ROOT_IN_W-1:0]      arg1_ff;

   logic                      p2_valid;
   ctx_type                   p2_ctx;
   logic signed [RATIO_W-1:0] p2_ratio;
   logic                      p2_clamp;
   logic [ROOT_W-1:0]         p2_root;

   logic                      m3_valid_ff;
   ctx_type                   m3_ctx_in;
   ctx_type                   m3_ctx_ff;
   logic signed [2*RATIO_W-1:0] cc2_prod;
   logic [ROOT_IN_W-1:0]      cc2_ff;

   logic                      m4_valid_ff;
   ctx_type                   m4_ctx_ff;
   logic [ROOT_IN_W-1:0]      arg2_ff;

   logic                      p3_valid;
   ctx_type                   p3_ctx;
   logic [ROOT_W-1:0]         p3_root;

   logic                      p4_valid;
   ctx_type                   p4_ctx;
   logic signed [ANGLE_W-1:0] z_beta;
   logic signed [ANGLE_W-1:0] z_link;
   logic signed [ANGLE_W-1:0] z_dir;

   logic signed [ANGLE_W-1:0] beta_full;
   logic signed [ANGLE_W-1:0] eef;
   logic signed [ANGLE_W-1:0] alpha_in;
   status_type                status_in;
   logic                      warn_in;

   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_base_ff;
   logic [ELBOW_W-1:0]        rsp_elbow_ff;
   status_type                rsp_status_ff;
   logic                      rsp_warn_ff;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_a_ff <= LINK_RESET;
         link_b_ff <= LINK_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_LINK_A: link_a_ff <= csr_data;
            CSR_LINK_B: link_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // squares and normalised direction vector
   always_comb begin
      xx_in = x_ff * x_ff;
      yy_in = y_ff * y_ff;
      abs_x = x_ff[COORD_W-1] ? COORD_W'(-x_ff) : COORD_W'(x_ff);
      abs_y = y_ff[COORD_W-1] ? COORD_W'(-y_ff) : COORD_W'(y_ff);
      norm_m = (abs_x > abs_y) ? NORM_W'(abs_x) : NORM_W'(abs_y);
      nx_in = NORM_W'(x_ff);
      ny_in = signed'(NORM_W'(abs_y));
      for (int j = 0; j < NORM_STEPS; j++) begin
         if (norm_m < (NORM_W'(1) << (NORM_W - 2 - (NORM_MAX_SHIFT >> j)))) begin
            norm_m = norm_m << (NORM_MAX_SHIFT >> j);
            nx_in = nx_in <<< (NORM_MAX_SHIFT >> j);
            ny_in = ny_in <<< (NORM_MAX_SHIFT >> j);
         end
      end
   end

   always_comb begin
      rr_in = xx_ff + yy_ff;
      num1_in = signed'(NUM_W'(aa_ff)) + signed'(NUM_W'(bb_ff)) - signed'(NUM_W'(rr_in));
      b_ctx_in = '0;
      b_ctx_in.y_neg = a_yneg_ff;
      b_ctx_in.rr_zero = (rr_in == '0);
      b_ctx_in.link_a = a_link_ff;
      b_ctx_in.num2 = signed'(NUM_W'(aa_ff)) + signed'(NUM_W'(rr_in)) - signed'(NUM_W'(bb_ff));
      b_ctx_in.norm_x = nx_ff;
      b_ctx_in.norm_y = ny_ff;
   end

   always_comb begin
      den2_prod = p1_ctx.link_a * p1_root;
      cc1_prod = p1_ratio * p1_ratio;
      m_ctx_in = p1_ctx;
      m_ctx_in.c1 = p1_ratio;
      m_ctx_in.clamp1 = p1_clamp;
      cc2_prod = p2_ratio * p2_ratio;
      m3_ctx_in = p2_ctx;
      m3_ctx_in.c2 = p2_ratio;
      m3_ctx_in.clamp2 = p2_clamp;
      m3_ctx_in.s1 = p2_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         m3_valid_ff <= 1'b0;
         m4_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
         a_valid_ff <= in_valid_ff;
         b_valid_ff <= a_valid_ff;
         m_valid_ff <= p1_valid;
         m2_valid_ff <= m_valid_ff;
         m3_valid_ff <= p2_valid;
         m4_valid_ff <= m3_valid_ff;
         rsp_valid_ff <= p4_valid;
      end
      if (advance) begin
         x_ff <= signed'(req_tdata[COORD_W-1:0]);
         y_ff <= signed'(req_tdata[2*COORD_W-1:COORD_W]);

         xx_ff <= xx_in;
         yy_ff <= yy_in;
         aa_ff <= link_a_ff * link_a_ff;
         bb_ff <= link_b_ff * link_b_ff;
         ab_ff <= link_a_ff * link_b_ff;
         a_link_ff <= link_a_ff;
         a_yneg_ff <= y_ff[COORD_W-1];
         nx_ff <= nx_in;
         ny_ff <= ny_in;

         rr_ff <= rr_in;
         num1_ff <= num1_in;
         den1_ff <= DEN_W'({ab_ff, 1'b0});
         b_ctx_ff <= b_ctx_in;

         m_ctx_ff <= m_ctx_in;
         den2_ff <= DEN_W'({den2_prod, 1'b0});
         cc1_ff <= ROOT_IN_W'(cc1_prod);

         m2_ctx_ff <= m_ctx_ff;
         m2_den_ff <= den2_ff;
         arg1_ff <= ONE_Q60 - cc1_ff;

         m3_ctx_ff <= m3_ctx_in;
         cc2_ff <= ROOT_IN_W'(cc2_prod);

         m4_ctx_ff <= m3_ctx_ff;
         arg2_ff <= ONE_Q60 - cc2_ff;

         rsp_base_ff <= alpha_in;
         rsp_elbow_ff <= beta_full[ELBOW_W-1:0];
         rsp_status_ff <= status_in;
         rsp_warn_ff <= warn_in;
      end
   end

   sik_isqrt u_root_r (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b_valid_ff),
      .in_ctx    (b_ctx_ff),
      .in_value  (ROOT_IN_W'(rr_ff)),
      .out_valid (),
      .out_ctx   (),
      .out_root  (p1_root)
   );

   sik_divider u_div_beta (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b_valid_ff),
      .in_ctx    (b_ctx_ff),
      .in_num    (num1_ff),
      .in_den    (den1_ff),
      .out_valid (p1_valid),
      .out_ctx   (p1_ctx),
      .out_ratio (p1_ratio),
      .out_clamp (p1_clamp)
   );

   sik_divider u_div_link (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m2_valid_ff),
      .in_ctx    (m2_ctx_ff),
      .in_num    (m2_ctx_ff.num2),
      .in_den    (m2_den_ff),
      .out_valid (p2_valid),
      .out_ctx   (p2_ctx),
      .out_ratio (p2_ratio),
      .out_clamp (p2_clamp)
   );

   sik_isqrt u_root_s1 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m2_valid_ff),
      .in_ctx    (m2_ctx_ff),
      .in_value  (arg1_ff),
      .out_valid (),
      .out_ctx   (),
      .out_root  (p2_root)
   );

   sik_isqrt u_root_s2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m4_valid_ff),
      .in_ctx    (m4_ctx_ff),
      .in_value  (arg2_ff),
      .out_valid (p3_valid),
      .out_ctx   (p3_ctx),
      .out_root  (p3_root)
   );

   sik_cordic u_cordic_beta (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p3_valid),
      .in_ctx    (p3_ctx),
      .in_cos    (p3_ctx.c1),
      .in_sin    (p3_ctx.s1),
      .out_valid (p4_valid),
      .out_ctx   (p4_ctx),
      .out_angle (z_beta)
   );

   sik_cordic u_cordic_link (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p3_valid),
      .in_ctx    (p3_ctx),
      .in_cos    (p3_ctx.c2),
      .in_sin    (p3_root),
      .out_valid (),
      .out_ctx   (),
      .out_angle (z_link)
   );

   sik_cordic u_cordic_dir (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p3_valid),
      .in_ctx    (p3_ctx),
      .in_cos    (p3_ctx.norm_x),
      .in_sin    (p3_ctx.norm_y[ROOT_W-1:0]),
      .out_valid (),
      .out_ctx   (),
      .out_angle (z_dir)
   );

   // mirror the direction below the X axis, then combine
   always_comb begin
      beta_full = Q_PI - z_beta;
      eef = p4_ctx.y_neg ? (Q_TWO_PI - z_dir) : z_dir;
      alpha_in = p4_ctx.rr_zero ? '0 : (eef - z_link);
      if (p4_ctx.rr_zero) begin
         status_in = STATUS_ORIGIN;
      end else if (p4_ctx.clamp1 || p4_ctx.clamp2) begin
         status_in = STATUS_CLAMPED;
      end else begin
         status_in = STATUS_OK;
      end
      warn_in = (alpha_in < -Q_PI);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, rsp_elbow_ff, rsp_base_ff};
   assign rsp_tuser = {rsp_warn_ff, rsp_status_ff};

   `SIK_ASSERT_IMPL(a_elbow_range, clock, reset, rsp_valid_ff, rsp_elbow_ff <= ELBOW_MAX)
   `SIK_ASSERT_IMPL(a_origin_base, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_ORIGIN), rsp_base_ff == '0)
   `SIK_ASSERT_IMPL(a_no_warning, clock, reset, rsp_valid_ff, !rsp_warn_ff)
   `SIK_ASSERT_NEXT(a_stall_holds_pipe, clock, reset,
      rsp_valid_ff && !rsp_tready && p4_valid, p4_valid)

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sik_pkg::*;

   localparam int LATENCY = 102 + CORDIC_STAGES;

   localparam logic signed [63:0] PI_Q = 64'sd843314857;
   localparam logic signed [63:0] TWO_PI_Q = 64'sd1686629713;
   localparam logic signed [63:0] HALF_PI_Q = 64'sd421657428;
   localparam logic signed [63:0] ONE_Q = 64'sd1073741824;

   localparam logic [LEN_W-1:0] LINK_SETS [4][2] = '{
      '{20'd1, 20'd1}, '{20'hfffff, 20'hfffff}, '{20'd30000, 20'd12000},
      '{20'd256, 20'hfffff}};

   typedef struct {
      logic signed [31:0] base;
      logic [29:0]        elbow;
      status_type         status;
      logic               warn;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LINK_A;
   logic [LEN_W-1:0] csr_data = '0;

   logic [LEN_W-1:0] link_a = LINK_RESET;
   logic [LEN_W-1:0] link_b = LINK_RESET;
   solution_type pending_solutions[$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int recv_hold = 0;

   scara_inverse_kinematics u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int k);
      return v >>> k;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] num);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > num) bitv >>= 2;
      while (bitv != 0) begin
         if (num >= res + bitv) begin
            num -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic signed [63:0] arc_angle(logic signed [63:0] c,
                                                    logic signed [63:0] s);
      logic signed [63:0] vx, vy, vz, dx, dy;
      vx = s;
      vy = -c;
      vz = HALF_PI_Q;
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         dx = floor_shift(vy, i);
         dy = floor_shift(vx, i);
         if (vy >= 0) begin
            vx += dx; vy -= dy; vz += 64'(atan_step(i));
         end else begin
            vx -= dx; vy += dy; vz -= 64'(atan_step(i));
         end
      end
      if (vz < 0) vz = 0;
      if (vz > PI_Q) vz = PI_Q;
      return vz;
   endfunction

   function automatic logic signed [63:0] cos_ratio(logic signed [63:0] n, logic [63:0] d,
                                                    output logic clamped);
      logic [63:0] mag, q, rem;
      logic neg;
      clamped = 1'b0;
      neg = n < 0;
      mag = neg ? -n : n;
      if (d == 0 || mag > d) begin
         clamped = 1'b1;
         return neg ? -ONE_Q : ONE_Q;
      end
      if (mag == d) return neg ? -ONE_Q : ONE_Q;
      q = 0;
      rem = mag;
      for (int i = 0; i < 30; i++) begin
         rem <<= 1;
         q <<= 1;
         if (rem >= d) begin
            rem -= d;
            q[0] = 1'b1;
         end
      end
      return neg ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [63:0] arc_cos(logic signed [63:0] c);
      logic [63:0] s;
      s = int_sqrt((64'd1 << 60) - 64'(c * c));
      return arc_angle(c, $signed(s));
   endfunction

   function automatic solution_type solve_joints(logic signed [23:0] tx,
                                                 logic signed [23:0] ty);
      solution_type o;
      logic signed [63:0] x, y, a, b, rr, aa, bb, c1, c2, beta, alpha, r, ax, ay, m, eef;
      logic cl1, cl2;
      int k;
      x = tx; y = ty; a = link_a; b = link_b;
      rr = x * x + y * y;
      aa = a * a; bb = b * b;
      alpha = 0; cl2 = 1'b0;
      c1 = cos_ratio(aa + bb - rr, 2 * a * b, cl1);
      beta = PI_Q - arc_cos(c1);
      o.status = STATUS_OK;
      if (rr == 0) begin
         o.status = STATUS_ORIGIN;
      end else begin
         r = int_sqrt(rr);
         ax = x < 0 ? -x : x;
         ay = y < 0 ? -y : y;
         m = ax > ay ? ax : ay;
         k = 0;
         while (m < (64'sd1 << 29)) begin
            m <<= 1;
            k++;
         end
         eef = arc_angle(x <<< k, ay <<< k);
         if (y < 0) eef = TWO_PI_Q - eef;
         c2 = cos_ratio(aa + rr - bb, 2 * a * r, cl2);
         alpha = eef - arc_cos(c2);
         if (cl1 || cl2) o.status = STATUS_CLAMPED;
      end
      o.base = alpha[31:0];
      o.elbow = beta[29:0];
      o.warn = alpha < -PI_Q;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, want %0d", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      solution_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_solutions.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = pending_solutions.pop_front();
            if ($signed(rsp_tdata[31:0]) != e.base)
               report_mismatch("base_angle", $signed(rsp_tdata[31:0]), e.base);
            if (rsp_tdata[61:32] != e.elbow)
               report_mismatch("elbow_angle", rsp_tdata[61:32], e.elbow);
            if (rsp_tdata[63:62] != 2'b00)
               report_mismatch("pad", rsp_tdata[63:62], 0);
            if (rsp_tuser[1:0] != e.status)
               report_mismatch("solve_status", rsp_tuser[1:0], e.status);
            if (rsp_tuser[2] != e.warn)
               report_mismatch("alpha_warning", rsp_tuser[2], e.warn);
         end
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_target(logic signed [23:0] tx, logic signed [23:0] ty);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {ty, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_solutions.push_back(solve_joints(tx, ty));
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_solutions.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_link(logic [LEN_W-1:0] len_a, logic [LEN_W-1:0] len_b);
      csr_valid <= 1'b1;
      csr_index <= CSR_LINK_A;
      csr_data <= len_a;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      link_a = len_a;
      @(negedge clock);
      csr_index <= CSR_LINK_B;
      csr_data <= len_b;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      link_b = len_b;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_targets(int count);
      logic signed [23:0] tx, ty;
      int reach;
      for (int i = 0; i < count; i++) begin
         reach = link_a + link_b;
         case ($urandom_range(3))
            0: begin
               tx = 24'($urandom);
               ty = 24'($urandom);
            end
            1: begin
               tx = 24'($signed($urandom_range(2 * reach)) - reach);
               ty = 24'($signed($urandom_range(2 * reach)) - reach);
            end
            2: begin
               tx = 24'($signed($urandom_range(511)) - 256);
               ty = 24'($signed($urandom_range(511)) - 256);
            end
            default: begin
               tx = $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
               ty = 24'($signed($urandom_range(2 * reach)) - reach);
            end
         endcase
         send_target(tx, ty);
      end
   endtask

   typedef struct {
      logic signed [23:0] tx;
      logic signed [23:0] ty;
      logic               known;
      logic signed [31:0] base;
      status_type         status;
   } target_row_type;

   localparam int N_ROWS = 14;
   target_row_type targets[N_ROWS] = '{
      '{24'sd0, 24'sd0, 1'b1, 32'sd0, STATUS_ORIGIN},
      '{24'sd51200, 24'sd0, 1'b0, 0, STATUS_OK},
      '{24'sh7fffff, 24'sh7fffff, 1'b0, 0, STATUS_OK},
      '{24'sh800000, 24'sh800000, 1'b0, 0, STATUS_OK},
      '{24'sh800000, 24'sh7fffff, 1'b0, 0, STATUS_OK},
      '{24'sh7fffff, 24'sh800000, 1'b0, 0, STATUS_OK},
      '{24'sd25600, 24'sd25600, 1'b0, 0, STATUS_OK},
      '{-24'sd25600, 24'sd10000, 1'b0, 0, STATUS_OK},
      '{24'sd100, -24'sd30000, 1'b0, 0, STATUS_OK},
      '{24'sd0, -24'sd1, 1'b0, 0, STATUS_OK},
      '{-24'sd1, 24'sd0, 1'b0, 0, STATUS_OK},
      '{24'sd1, 24'sd1, 1'b0, 0, STATUS_OK},
      '{24'sd60000, 24'sd0, 1'b0, 0, STATUS_OK},
      '{-24'sd51200, 24'sd0, 1'b0, 0, STATUS_OK}
   };

   initial begin
      solution_type e;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 27;
      recv_idle = 84;
      for (int i = 0; i < N_ROWS; i++) begin
         send_target(targets[i].tx, targets[i].ty);
         if (targets[i].known) begin
            // keep the predicted elbow, type in base, status and warning
            e = pending_solutions.pop_back();
            e.base = targets[i].base;
            e.status = targets[i].status;
            e.warn = 1'b0;
            pending_solutions.push_back(e);
         end
      end
      random_targets(300);
      drain_results();
      for (int s = 0; s < 4; s++) begin
         write_link(LINK_SETS[s][0], LINK_SETS[s][1]);
         send_idle = (s % 2 == 0) ? 84 : 0;
         recv_idle = (s % 2 == 0) ? 27 : 0;
         if (s == 2) recv_hold = 400;
         random_targets(300);
         drain_results();
      end
      write_link(LINK_RESET, LINK_RESET);
      random_targets(100);
      drain_results();
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
